>>> rtl/iirlp_pkg.sv
// ----------------------------------------------------------------------------
// iirlp_pkg
// Shared constants and coefficient tables for the seventh-order lowpass
// cascade. Coefficients are signed Q1.28.
// ----------------------------------------------------------------------------
package iirlp_pkg;

   localparam int FRAC_BITS      = 28;
   localparam int COEF_WIDTH     = 30;
   localparam int COEF_MAG_WIDTH = COEF_WIDTH - 1;
   localparam int GAIN_WIDTH     = 18;
   localparam int NUM_SECTIONS   = 4;

   typedef logic signed [COEF_WIDTH-1:0] coef_type;

   localparam logic signed [GAIN_WIDTH-1:0] GAIN_COEF = 18'sd129320;

   // The last entry describes the first-order section: its second feedback
   // term is zero and its feedforward term is exactly one.
   localparam coef_type FB_A [NUM_SECTIONS] = '{
      30'sd516267965, 30'sd510228701, 30'sd503361271, 30'sd249765534
   };
   localparam coef_type FB_B [NUM_SECTIONS] = '{
      -30'sd264602297, -30'sd254596183, -30'sd240582868, 30'sd0
   };
   localparam coef_type FF_A [NUM_SECTIONS] = '{
      -30'sd509812414, -30'sd500921150, -30'sd446739576, 30'sd268435456
   };

endpackage

>>> rtl/iirlp_section.sv
// ----------------------------------------------------------------------------
// iirlp_section
// One recursive section of the cascade with its delay registers and its
// output register. ORDER selects a second-order or first-order section.
// ----------------------------------------------------------------------------
module iirlp_section #(
   parameter int STATE_WIDTH = 48,
   parameter int ORDER       = 2,
   parameter int SECTION     = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic signed [STATE_WIDTH-1:0] in_data,
   output logic                          in_ready,
   output logic                          out_valid,
   output logic signed [STATE_WIDTH-1:0] out_data,
   input  logic                          out_ready
);
   import iirlp_pkg::*;

   localparam int MAGW = STATE_WIDTH + COEF_MAG_WIDTH + 1 - FRAC_BITS;
   localparam int PW   = STATE_WIDTH + COEF_MAG_WIDTH + 1;
   localparam logic [MAGW-1:0] LIM_POS = MAGW'({1'b0, {(STATE_WIDTH-1){1'b1}}});
   localparam logic [MAGW-1:0] LIM_NEG = LIM_POS + 1'b1;
   localparam logic [PW-1:0]   ROUND_HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
   localparam coef_type COEF_FB_A = FB_A[SECTION];
   localparam coef_type COEF_FB_B = FB_B[SECTION];
   localparam coef_type COEF_FF_A = FF_A[SECTION];

   function automatic logic signed [STATE_WIDTH-1:0] sat_add(
      input logic signed [STATE_WIDTH-1:0] a,
      input logic signed [STATE_WIDTH-1:0] b
   );
      logic [STATE_WIDTH:0] sum;
      logic signed [STATE_WIDTH-1:0] res;
      sum = {a[STATE_WIDTH-1], a} + {b[STATE_WIDTH-1], b};
      if (sum[STATE_WIDTH] != sum[STATE_WIDTH-1]) begin
         res = sum[STATE_WIDTH] ? ST_MIN : ST_MAX;
      end else begin
         res = sum[STATE_WIDTH-1:0];
      end
      return res;
   endfunction

   // Magnitude product rounded half away from zero, clamped, then signed.
   function automatic logic signed [STATE_WIDTH-1:0] mul_rnd(
      input logic signed [STATE_WIDTH-1:0] s,
      input coef_type k
   );
      logic neg;
      logic [STATE_WIDTH-1:0] m;
      logic [COEF_WIDTH-1:0] k_abs;
      logic [PW-1:0] p;
      logic [MAGW-1:0] mag;
      logic [MAGW-1:0] lim;
      logic [MAGW-1:0] res_ext;
      neg   = s[STATE_WIDTH-1] ^ k[COEF_WIDTH-1];
      m     = s[STATE_WIDTH-1] ? $unsigned(-s) : $unsigned(s);
      k_abs = k[COEF_WIDTH-1] ? $unsigned(-k) : $unsigned(k);
      p     = PW'(m) * PW'(k_abs[COEF_MAG_WIDTH-1:0]) + ROUND_HALF;
      mag   = p[PW-1:FRAC_BITS];
      lim   = neg ? LIM_NEG : LIM_POS;
      if (mag > lim) begin
         mag = lim;
      end
      res_ext = neg ? (MAGW'(0) - mag) : mag;
      return res_ext[STATE_WIDTH-1:0];
   endfunction

   logic                          fire;
   logic                          out_valid_ff, out_valid_in;
   logic signed [STATE_WIDTH-1:0] out_data_ff, out_data_in;
   logic signed [STATE_WIDTH-1:0] a_ff;
   logic signed [STATE_WIDTH-1:0] b_dly;
   logic signed [STATE_WIDTH-1:0] w_fb1, w_val;

   assign in_ready  = !out_valid_ff || out_ready;
   assign fire      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      w_fb1       = sat_add(in_data, mul_rnd(a_ff, COEF_FB_A));
      w_val       = sat_add(w_fb1, mul_rnd(b_dly, COEF_FB_B));
      out_data_in = sat_add(sat_add(w_val, mul_rnd(a_ff, COEF_FF_A)), b_dly);
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         a_ff         <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            a_ff <= w_val;
         end
      end
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   generate
      if (ORDER == 2) begin : g_second
         logic signed [STATE_WIDTH-1:0] b_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               b_ff <= '0;
            end else if (fire) begin
               b_ff <= a_ff;
            end
         end
         assign b_dly = b_ff;
      end else begin : g_first
         assign b_dly = '0;
      end
   endgenerate

   a_delay_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(a_ff))
      else $error("section delay changed without a beat");

   fire_fills_output: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("section output register not filled after a beat");

   held_output_stable: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ready |=> out_valid_ff && $stable(out_data_ff))
      else $error("section output lost while downstream was full");

endmodule

>>> rtl/iir_lowpass_cascade_core.sv
// ----------------------------------------------------------------------------
// iir_lowpass_cascade_core
// Seventh-order fixed-coefficient lowpass: input gain, three second-order
// sections and one first-order section, output rounded and saturated.
//
//   channel   ports                          direction
//   req       req_valid req_stall req_sample_in   in (stall out)
//   rsp       rsp_valid rsp_stall rsp_sample_out  out (stall in)
//
// One beat is taken every cycle while rsp is not stalled; a result passes
// through the input, gain, section output and rsp output registers in order.
// Each section's delay recursion (two products and two saturating adds
// feeding its own delay register) is a combinational loop, which sets the rate.
// Synchronous reset clears all delays and all stage valid flags.
// A stall on rsp backs up stage by stage; req_stall rises only when every
// stage holds a beat.
// ----------------------------------------------------------------------------
module iir_lowpass_cascade_core #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int STATE_WIDTH  = 48
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_in,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out
);
   import iirlp_pkg::*;

   localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH;
   localparam int EW = (PW > STATE_WIDTH) ? PW : STATE_WIDTH;
   localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
   localparam logic signed [STATE_WIDTH-1:0] SMP_MAX =
      STATE_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1);
   localparam logic signed [STATE_WIDTH-1:0] SMP_MIN = -SMP_MAX - 1;
   localparam logic [STATE_WIDTH:0] ROUND_HALF = (STATE_WIDTH + 1)'(1) << (FRAC_BITS - 1);

   logic                           in_valid_ff, in_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] in_sample_ff;
   logic                           in_ready;
   logic                           gain_valid_ff, gain_valid_in;
   logic signed [STATE_WIDTH-1:0]  gain_s_ff, gain_s_in;
   logic                           gain_ready;
   logic signed [PW-1:0]           gain_prod;
   logic signed [EW-1:0]           gain_ext;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out_ff, rsp_sample_out_in;
   logic                           out_ready;
   logic [STATE_WIDTH:0]           round_sum;
   logic signed [STATE_WIDTH-1:0]  y_round;
   logic signed [STATE_WIDTH-1:0]  y_int;
   logic signed [STATE_WIDTH-1:0]  y_clamp;

   logic                          sec_valid [NUM_SECTIONS+1];
   logic signed [STATE_WIDTH-1:0] sec_data  [NUM_SECTIONS+1];
   logic                          sec_ready [NUM_SECTIONS+1];

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign gain_ready = !gain_valid_ff || sec_ready[0];
   assign in_ready   = !in_valid_ff || gain_ready;
   assign req_stall  = !in_ready;

   assign sec_valid[0]            = gain_valid_ff;
   assign sec_data[0]             = gain_s_ff;
   assign sec_ready[NUM_SECTIONS] = out_ready;

   generate
      for (genvar i = 0; i < NUM_SECTIONS; i++) begin : g_sec
         iirlp_section #(
            .STATE_WIDTH (STATE_WIDTH),
            .ORDER       ((i == NUM_SECTIONS - 1) ? 1 : 2),
            .SECTION     (i)
         ) u_section (
            .clock     (clock),
            .reset     (reset),
            .in_valid  (sec_valid[i]),
            .in_data   (sec_data[i]),
            .in_ready  (sec_ready[i]),
            .out_valid (sec_valid[i+1]),
            .out_data  (sec_data[i+1]),
            .out_ready (sec_ready[i+1])
         );
      end
   endgenerate

   always_comb begin
      if (req_valid && in_ready) begin
         in_valid_in = 1'b1;
      end else if (gain_ready) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      gain_prod = in_sample_ff * GAIN_COEF;
      gain_ext  = EW'(gain_prod);
      if (gain_ext > EW'(ST_MAX)) begin
         gain_s_in = ST_MAX;
      end else if (gain_ext < EW'(ST_MIN)) begin
         gain_s_in = ST_MIN;
      end else begin
         gain_s_in = STATE_WIDTH'(gain_ext);
      end
      if (in_valid_ff && gain_ready) begin
         gain_valid_in = 1'b1;
      end else if (sec_ready[0]) begin
         gain_valid_in = 1'b0;
      end else begin
         gain_valid_in = gain_valid_ff;
      end

      round_sum = {sec_data[NUM_SECTIONS][STATE_WIDTH-1], sec_data[NUM_SECTIONS]}
                  + ROUND_HALF;
      if (round_sum[STATE_WIDTH] != round_sum[STATE_WIDTH-1]) begin
         y_round = ST_MAX;
      end else begin
         y_round = round_sum[STATE_WIDTH-1:0];
      end
      y_int = y_round >>> FRAC_BITS;
      if (y_int > SMP_MAX) begin
         y_clamp = SMP_MAX;
      end else if (y_int < SMP_MIN) begin
         y_clamp = SMP_MIN;
      end else begin
         y_clamp = y_int;
      end
      rsp_sample_out_in = y_clamp[SAMPLE_WIDTH-1:0];
      if (sec_valid[NUM_SECTIONS] && out_ready) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         gain_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         gain_valid_ff <= gain_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (req_valid && in_ready) begin
         in_sample_ff <= req_sample_in;
      end
      if (in_valid_ff && gain_ready) begin
         gain_s_ff <= gain_s_in;
      end
      if (sec_valid[NUM_SECTIONS] && out_ready) begin
         rsp_sample_out_ff <= rsp_sample_out_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   empty_output_never_stalls: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> !req_stall)
      else $error("input stalled although the output register is empty");

   no_result_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff)
      else $error("result beat present right after reset");

   result_from_last_section: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(sec_valid[NUM_SECTIONS]))
      else $error("result beat appeared without a beat from the last section");

endmodule
